// ===== src/mvm_pkg.sv =====
// shared types and constants for the matrix-vector multiply block
// no dependencies
`default_nettype none

package mvm_pkg;

   localparam logic [1:0] KIND_MAT_WRITE = 2'd0;
   localparam logic [1:0] KIND_VEC_WRITE = 2'd1;
   localparam logic [1:0] KIND_COMPUTE   = 2'd2;

   localparam int ROW_OUT_W = 4;
   localparam int SUM_W     = 48;
   localparam int FRAC_W    = 16;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // q16.16 value 1.0, the vector operand for a set mask bit
   localparam logic signed [31:0] MASK_ONE = 32'sh0001_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 load_mat;
      logic                 load_vec;
      logic                 start;
      logic                 issue;
      logic                 first;
      logic                 emit;
      logic                 last;
      logic [ROW_OUT_W-1:0] out_row;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== src/mvm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/mvm_ctrl.sv =====
// controller: sequences loads, row and column issue, drain and result emit
// depends on mvm_pkg
`default_nettype none

module mvm_ctrl #(
   parameter int ROWS = 16,
   parameter int COLS = 16,
   parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
   parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1,
   parameter int MAW  = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_kind,
   output logic                  req_stall,
   input  wire mvm_pkg::sts_type sts,
   output mvm_pkg::cmd_type      cmd,
   output logic      [MAW-1:0]   mat_rd_addr,
   output logic      [CW-1:0]    vec_rd_addr
);

   localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

   mvm_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [MAW-1:0]     addr_ff, addr_in;
   logic               accept;

   assign accept = req_valid && (state_ff == mvm_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mvm_pkg::ST_IDLE: begin
            if (req_valid && req_kind == mvm_pkg::KIND_COMPUTE) begin
               state_in = mvm_pkg::ST_ISSUE;
            end
         end
         mvm_pkg::ST_ISSUE: begin
            if (col_ff == COL_LAST) begin
               state_in = mvm_pkg::ST_DRAIN;
            end
         end
         mvm_pkg::ST_DRAIN: begin
            if (!sts.busy) begin
               state_in = mvm_pkg::ST_EMIT;
            end
         end
         mvm_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               state_in = (row_ff == ROW_LAST) ? mvm_pkg::ST_IDLE : mvm_pkg::ST_ISSUE;
            end
         end
         default: state_in = mvm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = (state_ff != mvm_pkg::ST_IDLE);
      cmd.load_mat = accept && (req_kind == mvm_pkg::KIND_MAT_WRITE);
      cmd.load_vec = accept && (req_kind == mvm_pkg::KIND_VEC_WRITE);
      cmd.start    = accept && (req_kind == mvm_pkg::KIND_COMPUTE);
      cmd.issue    = (state_ff == mvm_pkg::ST_ISSUE);
      cmd.first    = (state_ff == mvm_pkg::ST_ISSUE) && (col_ff == '0);
      cmd.emit     = (state_ff == mvm_pkg::ST_EMIT) && sts.out_free;
      cmd.last     = (row_ff == ROW_LAST);
      cmd.out_row  = mvm_pkg::ROW_OUT_W'(row_ff);
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      addr_in = addr_ff;
      case (state_ff)
         mvm_pkg::ST_IDLE: begin
            col_in  = '0;
            row_in  = '0;
            addr_in = '0;
         end
         mvm_pkg::ST_ISSUE: begin
            col_in  = (col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
            addr_in = addr_ff + 1'b1;
         end
         mvm_pkg::ST_EMIT: begin
            if (sts.out_free && row_ff != ROW_LAST) begin
               row_in = row_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvm_pkg::ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         addr_ff  <= addr_in;
      end
   end

   assign mat_rd_addr = addr_ff;
   assign vec_rd_addr = col_ff;

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted while output register is occupied");

   a_start_clears_counters: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == mvm_pkg::ST_ISSUE) && (col_ff == '0) && (row_ff == '0)
                    && (addr_ff == '0))
      else $error("compute run did not start at row and column zero");

   a_row_end_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mvm_pkg::ST_ISSUE && col_ff == COL_LAST) |=> state_ff == mvm_pkg::ST_DRAIN)
      else $error("issue did not stop at the last column");

endmodule

`default_nettype wire

// ===== src/mvm_dp.sv =====
// datapath: matrix and vector rams, multiply-accumulate pipeline, output register
// depends on mvm_pkg and mvm_ram
`default_nettype none

module mvm_dp #(
   parameter int ROWS = 16,
   parameter int COLS = 16,
   parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1,
   parameter int MAW  = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [3:0]              req_row_index,
   input  wire logic [3:0]              req_col_index,
   input  wire logic signed [31:0]      req_value,
   input  wire logic                    req_use_mask,
   input  wire logic [15:0]             req_mask,
   input  wire mvm_pkg::cmd_type        cmd,
   input  wire logic [MAW-1:0]          mat_rd_addr,
   input  wire logic [CW-1:0]           vec_rd_addr,
   output mvm_pkg::sts_type             sts,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic [3:0]                   rsp_out_row,
   output logic signed [47:0]           rsp_sum,
   output logic                         rsp_last
);

   localparam int AW = 64 + CW + 1;
   localparam int SW = AW - mvm_pkg::FRAC_W;
   localparam logic signed [SW-1:0] SAT_HI = SW'(mvm_pkg::SUM_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(mvm_pkg::SUM_MIN);

   logic               mat_wr_en, vec_wr_en;
   logic [MAW-1:0]     mat_wr_addr;
   logic [31:0]        mat_rd, vec_rd;

   logic               use_mask_ff;
   logic [15:0]        mask_ff;
   logic [15:0]        mask_sh;
   logic               s1_valid_ff, s1_first_ff;
   logic [CW-1:0]      s1_col_ff;
   logic               s2_valid_ff, s2_first_ff;
   logic signed [31:0] a_op, b_op;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] shifted;
   logic signed [47:0] sat_sum;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_row_ff;
   logic signed [47:0] rsp_sum_ff;
   logic               rsp_last_ff;

   assign mat_wr_en   = cmd.load_mat && (32'(req_row_index) < 32'(ROWS))
                        && (32'(req_col_index) < 32'(COLS));
   assign vec_wr_en   = cmd.load_vec && (32'(req_col_index) < 32'(COLS));
   assign mat_wr_addr = MAW'(32'(req_row_index) * 32'(COLS) + 32'(req_col_index));

   mvm_ram #(.WIDTH(32), .DEPTH(ROWS * COLS), .AW(MAW)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_wr_en),
      .wr_addr (mat_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd)
   );

   mvm_ram #(.WIDTH(32), .DEPTH(COLS), .AW(CW)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (CW'(req_col_index)),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd)
   );

   // columns past the mask width shift out to zero
   assign mask_sh = mask_ff >> s1_col_ff;
   assign a_op    = $signed(mat_rd);
   assign b_op    = use_mask_ff ? (mask_sh[0] ? mvm_pkg::MASK_ONE : 32'sd0) : $signed(vec_rd);
   assign prod_in = 64'(a_op) * 64'(b_op);
   assign acc_in  = s2_first_ff ? AW'(prod_ff) : acc_ff + AW'(prod_ff);

   assign shifted = SW'(acc_ff >>> mvm_pkg::FRAC_W);

   always_comb begin
      if (shifted > SAT_HI) begin
         sat_sum = mvm_pkg::SUM_MAX;
      end else if (shifted < SAT_LO) begin
         sat_sum = mvm_pkg::SUM_MIN;
      end else begin
         sat_sum = 48'(shifted);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         use_mask_ff <= req_use_mask;
         mask_ff     <= req_mask;
      end
      s1_first_ff <= cmd.first;
      s1_col_ff   <= vec_rd_addr;
      s2_first_ff <= s1_first_ff;
      if (s1_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.emit) begin
         rsp_row_ff  <= cmd.out_row;
         rsp_sum_ff  <= sat_sum;
         rsp_last_ff <= cmd.last;
      end
   end

   assign sts.busy     = s1_valid_ff || s2_valid_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_sum     = rsp_sum_ff;
   assign rsp_last    = rsp_last_ff;

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !s1_valid_ff && !s2_valid_ff)
      else $error("row emitted before the accumulate pipeline drained");

   a_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted row not presented on the result channel");

endmodule

`default_nettype wire

// ===== src/matrix_vector_multiply_top.sv =====
// top level of the matrix-vector multiply block
// depends on mvm_pkg, mvm_ctrl, mvm_dp, mvm_ram
//
//   channel  handshake              payload
//   req      req_valid / req_stall  kind, row_index, col_index, value, use_mask, mask
//   rsp      rsp_valid / rsp_stall  out_row, sum, last
//
// load transactions (matrix or vector element) write one ram element when accepted and in range
// a compute transaction can be held up by result stalls; one
// shared multiply-accumulate unit walks the matrix ram one element per cycle, then drains
// the pipeline and emits one result per row
// req_stall is high from compute accept until the final row is in the output register
// synchronous active-high reset; ram contents are not cleared
`default_nettype none

module matrix_vector_multiply_top #(
   parameter int ROWS = 16,
   parameter int COLS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [3:0]         req_row_index,
   input  wire logic [3:0]         req_col_index,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_use_mask,
   input  wire logic [15:0]        req_mask,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_out_row,
   output logic signed [47:0]      rsp_sum,
   output logic                    rsp_last
);

   localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int MAW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;

   mvm_pkg::cmd_type cmd;
   mvm_pkg::sts_type sts;
   logic [MAW-1:0]   mat_rd_addr;
   logic [CW-1:0]    vec_rd_addr;

   mvm_ctrl #(.ROWS(ROWS), .COLS(COLS), .RW(RW), .CW(CW), .MAW(MAW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd),
      .mat_rd_addr (mat_rd_addr),
      .vec_rd_addr (vec_rd_addr)
   );

   mvm_dp #(.ROWS(ROWS), .COLS(COLS), .CW(CW), .MAW(MAW)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_value     (req_value),
      .req_use_mask  (req_use_mask),
      .req_mask      (req_mask),
      .cmd           (cmd),
      .mat_rd_addr   (mat_rd_addr),
      .vec_rd_addr   (vec_rd_addr),
      .sts           (sts),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_row   (rsp_out_row),
      .rsp_sum       (rsp_sum),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
